@@ design/rotc_pkg.sv @@
`timescale 1ns / 1ps
package rotc_pkg;

  localparam int unsigned CORDIC_STEPS = 20;
  localparam int unsigned CW = 34;   // cordic datapath width
  localparam int unsigned RW = 38;   // rotation intermediate width
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QAW = $clog2(QUEUE_DEPTH);

  localparam logic signed [CW-1:0] CORDIC_START = 34'sd652032874;

  localparam logic [31:0] ATAN_TURN [CORDIC_STEPS] = '{
    32'd536870912, 32'd316933405, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335086,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41721,
    32'd20860, 32'd10430, 32'd5215, 32'd2607, 32'd1303
  };

  // register indexes
  localparam logic [1:0] REG_CENTER_X = 2'd0;
  localparam logic [1:0] REG_CENTER_Y = 2'd1;
  localparam logic [1:0] REG_CENTER_Z = 2'd2;

  typedef struct packed {
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic [15:0]        angle_about_x;
    logic [15:0]        angle_about_y;
    logic [15:0]        angle_about_z;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] rotated_x;
    logic signed [31:0] rotated_y;
    logic signed [31:0] rotated_z;
  } out_item_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } center_t;

  typedef struct packed {
    logic signed [32:0] dx;
    logic signed [32:0] dy;
    logic signed [32:0] dz;
    logic [15:0]        ang_x;
    logic [15:0]        ang_y;
    logic [15:0]        ang_z;
  } work_t;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
  } cordic_t;

  typedef struct packed {
    logic signed [16:0] s;
    logic signed [16:0] c;
  } sincos_t;

  function automatic cordic_t cordic_init(logic [15:0] ang);
    cordic_t r;
    r.x = CORDIC_START;
    r.y = '0;
    r.z = $signed({4'b0000, ang[13:0], 16'b0});
    return r;
  endfunction

  function automatic cordic_t cordic_step(cordic_t a, int unsigned i);
    cordic_t r;
    logic signed [CW-1:0] xs;
    logic signed [CW-1:0] ys;
    logic signed [CW-1:0] at;
    xs = a.x >>> i;
    ys = a.y >>> i;
    at = $signed({2'b00, ATAN_TURN[i]});
    if (!a.z[CW-1]) begin
      r.x = a.x - ys;
      r.y = a.y + xs;
      r.z = a.z - at;
    end else begin
      r.x = a.x + ys;
      r.y = a.y - xs;
      r.z = a.z + at;
    end
    return r;
  endfunction

  function automatic logic signed [16:0] to_q15(logic signed [CW-1:0] v);
    logic signed [CW:0] t;
    t = ($signed({v[CW-1], v}) + 35'sd16384) >>> 15;
    if (t > 35'sd32768) return 17'sd32768;
    if (t < -35'sd32768) return -17'sd32768;
    return 17'(t);
  endfunction

  function automatic sincos_t quad_map(cordic_t a, logic [1:0] quad);
    sincos_t r;
    logic signed [16:0] c;
    logic signed [16:0] s;
    c = to_q15(a.x);
    s = to_q15(a.y);
    case (quad)
      2'd0: begin r.c = c;  r.s = s;  end
      2'd1: begin r.c = -s; r.s = c;  end
      2'd2: begin r.c = -c; r.s = -s; end
      default: begin r.c = s; r.s = -c; end
    endcase
    return r;
  endfunction

  // a*ca + b*cb, round half up, Q15
  function automatic logic signed [RW-1:0] mix(logic signed [RW-1:0] a,
                                               logic signed [16:0] ca,
                                               logic signed [RW-1:0] b,
                                               logic signed [16:0] cb);
    logic signed [RW+17:0] acc;
    acc = (RW+18)'(a) * (RW+18)'(ca) + (RW+18)'(b) * (RW+18)'(cb)
          + (RW+18)'(16384);
    return RW'(acc >>> 15);
  endfunction

  function automatic logic signed [31:0] sat_add(logic signed [31:0] c,
                                                 logic signed [RW-1:0] d);
    logic signed [RW:0] v;
    v = (RW+1)'(c) + (RW+1)'(d);
    if (v > (RW+1)'(64'sd2147483647)) return 32'sh7fffffff;
    if (v < -(RW+1)'(64'sd2147483648)) return 32'sh80000000;
    return 32'(v);
  endfunction

endpackage

@@ design/euler_rotate_point_about_center.sv @@
`timescale 1ns / 1ps
// Rotates a Q16.16 point about a programmable centre: about z by gamma,
// then x by alpha, then y by beta (16-bit binary angles).
// Channels:
//   in_*  : point beat (valid/ready), accepted when both are high.
//   out_* : rotated point beat (valid/ready), held until taken.
//   cfg_* : register write beat; index 0/1/2 = centre x/y/z, index 3 ignored.
//           cfg_ready is always high; write only while the block is idle.
// Throughput: one point per cycle, sustained while out_ready stays high.
// Pipeline from input beat to output valid: input register, queue,
//   20 CORDIC stages, sin/cos stage, three rotation stages, output.
// The CORDIC pipeline sets the depth; each rotation stage is one pair of
// multiply-adds.
// Reset: all beats in flight are dropped, centre returns to the origin.
// Receiver stall: the back pipe freezes as a unit; the 4-entry queue and
// input register keep absorbing beats until full, then in_ready drops.
module euler_rotate_point_about_center (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  rotc_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output rotc_pkg::out_item_t out_item,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [31:0]         cfg_data
);
  import rotc_pkg::*;

  center_t center;
  logic    f_valid;
  logic    f_ready;
  work_t   f_work;
  logic    q_valid;
  logic    q_ready;
  work_t   q_work;

  assign cfg_ready = 1'b1;

  // centre registers
  always_ff @(posedge clk) begin
    if (rst) begin
      center <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_CENTER_X: center.x <= cfg_data;
        REG_CENTER_Y: center.y <= cfg_data;
        REG_CENTER_Z: center.z <= cfg_data;
        default: ;
      endcase
    end
  end

  rotc_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .center   (center),
    .f_valid  (f_valid),
    .f_ready  (f_ready),
    .f_work   (f_work)
  );

  rotc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_data  (f_work),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_data   (q_work)
  );

  rotc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_work    (q_work),
    .center    (center),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );
endmodule

@@ design/rotc_front.sv @@
`timescale 1ns / 1ps
module rotc_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  rotc_pkg::in_item_t in_item,
  input  rotc_pkg::center_t  center,
  output logic              f_valid,
  input  logic              f_ready,
  output rotc_pkg::work_t    f_work
);
  import rotc_pkg::*;

  assign in_ready = !f_valid || f_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (in_ready) begin
      f_valid <= in_valid;
    end
  end

  // offsets from centre, exact 33 bits
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      f_work.dx    <= 33'(in_item.point_x) - 33'(center.x);
      f_work.dy    <= 33'(in_item.point_y) - 33'(center.y);
      f_work.dz    <= 33'(in_item.point_z) - 33'(center.z);
      f_work.ang_x <= in_item.angle_about_x;
      f_work.ang_y <= in_item.angle_about_y;
      f_work.ang_z <= in_item.angle_about_z;
    end
  end
endmodule

@@ design/rotc_queue.sv @@
`timescale 1ns / 1ps
module rotc_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push_valid,
  output logic           push_ready,
  input  rotc_pkg::work_t push_data,
  output logic           pop_valid,
  input  logic           pop_ready,
  output rotc_pkg::work_t pop_data
);
  import rotc_pkg::*;

  work_t           mem [QUEUE_DEPTH];
  logic [QAW-1:0]  wr_ptr;
  logic [QAW-1:0]  rd_ptr;
  logic [QAW:0]    count;
  logic            push;
  logic            pop;

  assign push_ready = count != (QAW+1)'(QUEUE_DEPTH);
  assign pop_valid  = count != '0;
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_data   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      count <= count + (QAW+1)'(push) - (QAW+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_data;
  end
endmodule

@@ design/rotc_back.sv @@
`timescale 1ns / 1ps
module rotc_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  output logic              q_ready,
  input  rotc_pkg::work_t    q_work,
  input  rotc_pkg::center_t  center,
  output logic              out_valid,
  input  logic              out_ready,
  output rotc_pkg::out_item_t out_item
);
  import rotc_pkg::*;

  logic    adv;
  cordic_t cs [CORDIC_STEPS][3];
  work_t   cw [CORDIC_STEPS];
  logic    cv [CORDIC_STEPS];
  cordic_t c_in [3];

  // sine/cosine stage: index 0 alpha, 1 beta, 2 gamma
  sincos_t qsc [3];
  work_t   qw;
  logic    qv;

  logic signed [RW-1:0] zx1, zy1, zdz;
  sincos_t zsa, zsb;
  logic    zv;

  logic signed [RW-1:0] xx1, xy2, xz2;
  sincos_t xsb;
  logic    xv;

  logic signed [RW-1:0] yy2, yx3, yz3;
  logic    yv;

  // whole pipe moves when the output slot is free
  assign adv     = !out_valid || out_ready;
  assign q_ready = adv;

  assign c_in[0] = cordic_init(q_work.ang_x);
  assign c_in[1] = cordic_init(q_work.ang_y);
  assign c_in[2] = cordic_init(q_work.ang_z);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CORDIC_STEPS; i++) cv[i] <= 1'b0;
      qv <= 1'b0;
      zv <= 1'b0;
      xv <= 1'b0;
      yv <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      cv[0] <= q_valid;
      for (int i = 1; i < CORDIC_STEPS; i++) cv[i] <= cv[i-1];
      qv <= cv[CORDIC_STEPS-1];
      zv <= qv;
      xv <= zv;
      yv <= xv;
      out_valid <= yv;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        cs[0][k] <= cordic_step(c_in[k], 0);
        for (int i = 1; i < CORDIC_STEPS; i++) begin
          cs[i][k] <= cordic_step(cs[i-1][k], i);
        end
      end
      cw[0] <= q_work;
      for (int i = 1; i < CORDIC_STEPS; i++) cw[i] <= cw[i-1];

      qsc[0] <= quad_map(cs[CORDIC_STEPS-1][0], cw[CORDIC_STEPS-1].ang_x[15:14]);
      qsc[1] <= quad_map(cs[CORDIC_STEPS-1][1], cw[CORDIC_STEPS-1].ang_y[15:14]);
      qsc[2] <= quad_map(cs[CORDIC_STEPS-1][2], cw[CORDIC_STEPS-1].ang_z[15:14]);
      qw     <= cw[CORDIC_STEPS-1];

      // about z by gamma
      zx1 <= mix(RW'(qw.dx), qsc[2].c, RW'(qw.dy), -qsc[2].s);
      zy1 <= mix(RW'(qw.dx), qsc[2].s, RW'(qw.dy), qsc[2].c);
      zdz <= RW'(qw.dz);
      zsa <= qsc[0];
      zsb <= qsc[1];

      // about x by alpha
      xy2 <= mix(zy1, zsa.c, zdz, -zsa.s);
      xz2 <= mix(zy1, zsa.s, zdz, zsa.c);
      xx1 <= zx1;
      xsb <= zsb;

      // about y by beta
      yx3 <= mix(xz2, xsb.s, xx1, xsb.c);
      yz3 <= mix(xz2, xsb.c, xx1, -xsb.s);
      yy2 <= xy2;

      out_item.rotated_x <= sat_add(center.x, yx3);
      out_item.rotated_y <= sat_add(center.y, yy2);
      out_item.rotated_z <= sat_add(center.z, yz3);
    end
  end
endmodule
